// ===== hdl/weacc_pkg.sv =====
// Shared types and constants for the wrap-extending energy accumulator.
// No dependencies; used by every module of the block by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package weacc_pkg;

  // Microjoules per joule, used for the unit conversion
  localparam logic [19:0] UJ_PER_J = 20'd1000000;

  // Reset value of the unit exponent register
  localparam logic [4:0] EXP_RESET = 5'd16;

  // One input beat
  typedef struct packed {
    logic [5:0]  channel;
    logic [31:0] raw_count;
  } in_item_t;

  // One result beat
  typedef struct packed {
    logic [5:0]  channel_out;
    logic [63:0] energy_uj;
  } out_item_t;

  // Updated channel total handed from the tracker to the scaler
  typedef struct packed {
    logic        valid;
    logic        in_range;
    logic [5:0]  channel;
    logic [63:0] total;
  } total_beat_t;

endpackage

`default_nettype wire

// ===== hdl/weacc_track.sv =====
// Per-channel state tracker: sample/total memory, read-modify-write with bypass,
// and the clearing pass after reset. Uses weacc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module weacc_track #(
  parameter int CHANNELS = 64
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    accept,
  input  weacc_pkg::in_item_t    item,
  output logic                   clearing,
  output weacc_pkg::total_beat_t beat
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Each entry: {last sample, accumulated total}
  logic [95:0] mem [CHANNELS];
  logic [95:0] rd_data;

  logic [AW-1:0] clr_addr;

  // Stage 1 registers (item whose entry is being read back)
  logic          s1_valid;
  logic          s1_in_range;
  logic [5:0]    s1_channel;
  logic [31:0]   s1_sample;
  logic [AW-1:0] s1_addr;

  // Bypass of the entry written by the previous item
  logic          fwd_hit;
  logic [31:0]   fwd_sample;
  logic [63:0]   fwd_total;

  logic [AW+5:0] ch_wide;
  logic [AW-1:0] in_addr;
  logic          in_range;
  logic [31:0]   old_sample;
  logic [63:0]   old_total;
  logic [31:0]   delta;
  logic [63:0]   total_next;

  assign ch_wide  = {{AW{1'b0}}, item.channel};
  assign in_addr  = ch_wide[AW-1:0];
  assign in_range = ({26'd0, item.channel} < 32'(CHANNELS));

  // Current entry: memory or the value just written by the prior item
  assign old_sample = fwd_hit ? fwd_sample : rd_data[95:64];
  assign old_total  = fwd_hit ? fwd_total  : rd_data[63:0];

  // Wrap-aware delta and new total, both modulo their widths
  assign delta      = s1_sample - old_sample;
  assign total_next = old_total + {32'd0, delta};

  // Clearing pass: one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(CHANNELS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (s1_valid && s1_in_range) begin
      mem[s1_addr] <= {s1_sample, total_next};
    end
    rd_data <= mem[in_addr];
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= accept;
      fwd_hit  <= accept && s1_valid && s1_in_range && in_range && (s1_addr == in_addr);
    end
  end

  // Stage 1 payload and bypass data
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in_range <= in_range;
      s1_channel  <= item.channel;
      s1_sample   <= item.raw_count;
      s1_addr     <= in_addr;
    end
    fwd_sample <= s1_sample;
    fwd_total  <= total_next;
  end

  // Output register toward the scaler
  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else begin
      beat.valid <= s1_valid;
    end
    beat.in_range <= s1_in_range;
    beat.channel  <= s1_channel;
    beat.total    <= total_next;
  end

endmodule

`default_nettype wire

// ===== hdl/weacc_scale.sv =====
// Unit conversion: total * 1e6 modulo 2^64 in two 32-bit halves, then right shift
// by the unit exponent; out-of-range channels give zero. Uses weacc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module weacc_scale (
  input  wire                    clk,
  input  wire                    rst,
  input  weacc_pkg::total_beat_t beat,
  input  wire  [4:0]             unit_exp,
  output logic                   result_valid,
  output weacc_pkg::out_item_t   result
);

  logic        p_valid;
  logic        p_in_range;
  logic [5:0]  p_channel;
  logic [51:0] lo_prod;
  logic [31:0] hi_prod;

  logic [51:0] lo_prod_next;
  logic [51:0] hi_prod_full;
  logic [63:0] product;
  logic [63:0] shifted;

  // Partial products of the low and high halves
  assign lo_prod_next = beat.total[31:0]  * weacc_pkg::UJ_PER_J;
  assign hi_prod_full = beat.total[63:32] * weacc_pkg::UJ_PER_J;

  // Recombine modulo 2^64 and scale
  assign product = {12'd0, lo_prod} + {hi_prod, 32'd0};
  assign shifted = product >> unit_exp;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      p_valid      <= beat.valid;
      result_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    p_in_range         <= beat.in_range;
    p_channel          <= beat.channel;
    lo_prod            <= lo_prod_next;
    hi_prod            <= hi_prod_full[31:0];
    result.channel_out <= p_channel;
    result.energy_uj   <= p_in_range ? shifted : 64'd0;
  end

endmodule

`default_nettype wire

// ===== hdl/wrap_extending_energy_accumulator.sv =====
// Top level of the wrap-extending energy accumulator.
// Instantiates weacc_track and weacc_scale; uses weacc_pkg.
//
// Usage:
//   Input: drive item (channel, raw_count) with start high; the beat is taken
//   at a rising edge where start is high and busy is low. One beat can be
//   taken every cycle.
//   Output: each beat yields exactly one result, shown on result for one
//   cycle with result_valid high. The receiver cannot stall; results come in
//   input order.
//   Config: cfg_we with cfg_wdata writes the unit exponent (reset 16); write
//   only while no beat is in flight.
//   Rate: one beat per cycle when not busy. The per-channel memory read is
//   registered and the entry written by the previous beat is bypassed, so
//   back-to-back beats on the same channel need no wait. Four register
//   stages: memory read, total update, split multiply, recombine and shift.
//   Reset: rst (synchronous) starts a clearing pass that zeroes one channel
//   entry per cycle; busy stays high until every entry is cleared.
//   Channels at or above CHANNELS leave state alone and report zero energy.
`timescale 1ns / 1ps
`default_nettype none

module wrap_extending_energy_accumulator #(
  parameter int CHANNELS = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  weacc_pkg::in_item_t  item,
  input  wire                  cfg_we,
  input  wire  [4:0]           cfg_wdata,
  output logic                 result_valid,
  output weacc_pkg::out_item_t result
);

  logic                   accept;
  logic                   clearing;
  logic [4:0]             unit_exp;
  weacc_pkg::total_beat_t beat;

  assign busy   = clearing;
  assign accept = start && !clearing;

  // Unit exponent register
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_exp <= weacc_pkg::EXP_RESET;
    end else if (cfg_we) begin
      unit_exp <= cfg_wdata;
    end
  end

  weacc_track #(
    .CHANNELS(CHANNELS)
  ) u_track (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .clearing (clearing),
    .beat     (beat)
  );

  weacc_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .beat         (beat),
    .unit_exp     (unit_exp),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== tb/energy_total_checker.sv =====
// Checker for the wrap-extending energy accumulator: watches the input, config and
// result channels, keeps its own per-channel totals and compares every result beat.
// Depends on weacc_pkg for the beat types.
`timescale 1ns / 1ps

module energy_total_checker #(
  parameter int CHANNELS = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire                  busy,
  input  weacc_pkg::in_item_t  item,
  input  wire                  cfg_we,
  input  wire  [4:0]           cfg_wdata,
  input  wire                  result_valid,
  input  weacc_pkg::out_item_t result,
  output int                   errors,
  output int                   pending,
  output int                   beats_out
);

  localparam logic [63:0] MICRO_PER_UNIT = 64'd1000000;
  localparam logic [4:0]  RESET_EXP      = 5'd16;
  localparam int          MAX_PRINTS     = 40;

  // Shadow copy of the per-channel stores and the unit exponent
  logic [31:0] prev_sample   [CHANNELS];
  logic [63:0] channel_total [CHANNELS];
  logic [4:0]  unit_exp;

  weacc_pkg::out_item_t expected_totals[$];
  int err_count = 0;
  int out_count = 0;

  // Fold one sample into its channel and return the microjoule reading
  function automatic weacc_pkg::out_item_t accumulate_sample(weacc_pkg::in_item_t beat);
    weacc_pkg::out_item_t res;
    logic [31:0] delta;
    logic [63:0] product;
    res.channel_out = beat.channel;
    res.energy_uj   = '0;
    if (int'(beat.channel) < CHANNELS) begin
      // mod 2^32 difference handles a counter wrap
      delta = beat.raw_count - prev_sample[beat.channel];
      channel_total[beat.channel] = channel_total[beat.channel] + {32'd0, delta};
      prev_sample[beat.channel] = beat.raw_count;
      // product kept to 64 bits before the shift
      product = channel_total[beat.channel] * MICRO_PER_UNIT;
      res.energy_uj = product >> unit_exp;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < MAX_PRINTS)
      $display("MISMATCH result beat %0d, %s: got 0x%016h, expected 0x%016h",
               out_count, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : watch
    weacc_pkg::out_item_t want;
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prev_sample[i]   = '0;
        channel_total[i] = '0;
      end
      unit_exp = RESET_EXP;
      expected_totals.delete();
    end else begin
      if (cfg_we) unit_exp = cfg_wdata;

      // Compare result first: nothing accepted this edge can come out yet
      if (result_valid) begin
        if (expected_totals.size() == 0) begin
          report_mismatch("no beat outstanding, channel", {58'd0, result.channel_out}, '0);
        end else begin
          want = expected_totals.pop_front();
          if (result.channel_out !== want.channel_out)
            report_mismatch("channel_out", {58'd0, result.channel_out},
                            {58'd0, want.channel_out});
          if (result.energy_uj !== want.energy_uj)
            report_mismatch("energy_uj", result.energy_uj, want.energy_uj);
        end
        out_count++;
      end

      if (start && !busy) expected_totals.push_back(accumulate_sample(item));
    end
    errors    <= err_count;
    pending   <= expected_totals.size();
    beats_out <= out_count;
  end

endmodule

// ===== tb/wrap_extending_energy_accumulator_tb.sv =====
// Testbench top for the wrap-extending energy accumulator: clock, reset, stimulus
// and verdict. Depends on weacc_pkg, the block and energy_total_checker.
`timescale 1ns / 1ps

module wrap_extending_energy_accumulator_tb;

  localparam int CHANNELS    = 64;
  localparam int LATENCY     = 4;
  localparam int STALL_LIMIT = 1000;
  localparam int BURST_BEATS = 50;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  weacc_pkg::in_item_t  item;
  logic                 cfg_we;
  logic [4:0]           cfg_wdata;
  logic                 result_valid;
  weacc_pkg::out_item_t result;

  int errors;
  int pending;
  int beats_out;

  int          idle_pct = 0;
  int          beats_sent = 0;
  int          stall_cycles = 0;
  logic [5:0]  prev_ch = '0;
  logic [31:0] drv_last [CHANNELS];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  wrap_extending_energy_accumulator #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .result_valid(result_valid),
    .result      (result)
  );

  energy_total_checker #(
    .CHANNELS(CHANNELS)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .result_valid(result_valid),
    .result      (result),
    .errors      (errors),
    .pending     (pending),
    .beats_out   (beats_out)
  );

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // One input beat, with random sender gaps ahead of it
  task automatic send_beat(input logic [5:0] ch, input logic [31:0] raw);
    weacc_pkg::in_item_t beat;
    beat.channel   = ch;
    beat.raw_count = raw;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= beat;
    do @(posedge clk); while (busy);
    drv_last[ch] = raw;
    prev_ch = ch;
    beats_sent++;
  endtask

  // Mostly counter-like samples: small steps, some wraps, some junk
  task automatic run_random(input int count);
    logic [5:0]  ch;
    logic [31:0] raw;
    int          pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      ch = prev_ch;
      else if (pick < 60) ch = 6'($urandom_range(0, 3));
      else                ch = 6'($urandom_range(0, CHANNELS - 1));
      pick = $urandom_range(0, 99);
      if (pick < 45)      raw = drv_last[ch] + 32'($urandom_range(0, 65535));
      else if (pick < 65) raw = drv_last[ch] + $urandom;
      else if (pick < 80) raw = $urandom;
      else if (pick < 90) raw = drv_last[ch];
      else                raw = drv_last[ch] - 32'd1;
      send_beat(ch, raw);
    end
  endtask

  // Wait out every beat in flight, then write the unit exponent
  task automatic drain_and_set_exp(input logic [4:0] exp_val);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= exp_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0] burst_raw;
    for (int i = 0; i < CHANNELS; i++) drv_last[i] = '0;
    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: first samples and a wrap at the reset exponent
    send_beat(6'd0, 32'h0000_0000);
    send_beat(6'd0, 32'hFFFF_FFFF);
    send_beat(6'd0, 32'h0000_0000);

    // Exponent 0: raw totals times one million
    drain_and_set_exp(5'd0);
    send_beat(6'd63, 32'hFFFF_FFFF);
    send_beat(6'd63, 32'h8000_0000);
    send_beat(6'd1,  32'hAAAA_AAAA);
    send_beat(6'd1,  32'h5555_5555);
    send_beat(6'd2,  32'h1234_5678);
    send_beat(6'd2,  32'h1234_5678);
    send_beat(6'd42, 32'h0000_FFFF);
    send_beat(6'd21, 32'hFFFF_0000);
    send_beat(6'd42, 32'h0000_FFFE);
    send_beat(6'd63, 32'hFFFF_FFFF);
    send_beat(6'd0,  32'h0000_0001);
    send_beat(6'd0,  32'h0000_0000);
    send_beat(6'd3,  32'h0000_0000);
    send_beat(6'd3,  32'hFFFF_FFFF);

    // Light sender gaps, top exponent
    drain_and_set_exp(5'd31);
    idle_pct = 13;
    run_random(350);

    // Heavy sender gaps, mid exponent
    drain_and_set_exp(5'($urandom_range(1, 30)));
    idle_pct = 60;
    run_random(350);

    // Back to back at the reset exponent
    drain_and_set_exp(5'd16);
    idle_pct = 0;
    run_random(360);

    // Near-max deltas on one channel, back to back, to push its total up
    burst_raw = drv_last[9];
    repeat (BURST_BEATS) begin
      burst_raw = burst_raw - 32'd1 - 32'($urandom_range(0, 3));
      send_beat(6'd9, burst_raw);
    end
    run_random(20);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Run covered %0d sample beats and %0d result beats across 64 channels,",
             beats_sent, beats_out);
    $display("exponents 0, 31, 16 and a random one, counter wraps, and near-max deltas.");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
